/* rtl/km2d_pkg.sv */
// package for the 2d k-means pass block
// holds field widths, op and kind codes, the token struct and the cell control struct
package km2d_pkg;
  localparam int unsigned MaxClusters = 6;
  localparam int unsigned CoordBits   = 12;
  localparam int unsigned IdBits      = 3;
  localparam int unsigned SumBits     = 36;
  localparam int unsigned CntBits     = 25;
  localparam int unsigned DistBits    = 2 * CoordBits + 1;

  localparam logic OpSeed  = 1'b0;
  localparam logic OpPixel = 1'b1;
  localparam logic KindLabel = 1'b0;
  localparam logic KindMean  = 1'b1;

  // token handed from cell to cell during the distance search
  typedef struct packed {
    logic                  vld;
    logic                  lastp;
    logic [CoordBits-1:0]  px;
    logic [CoordBits-1:0]  py;
    logic [DistBits-1:0]   bd;
    logic [IdBits-1:0]     best;
  } km2d_tok_t;

  typedef struct packed {
    logic                  seed_we;
    logic                  add_en;
    logic [IdBits-1:0]     add_id;
    logic [CoordBits-1:0]  add_x;
    logic [CoordBits-1:0]  add_y;
    logic                  clr;
    logic                  ld;
    logic [CoordBits-1:0]  ld_x;
    logic [CoordBits-1:0]  ld_y;
    logic [CoordBits-1:0]  seed_x;
    logic [CoordBits-1:0]  seed_y;
  } km2d_ctl_t;
endpackage

/* rtl/kmeans_2d_point_cluster_pass_top.sv */
// top level of the 2d k-means pass: chain of six cluster cells and mean update
// depends on km2d_pkg, km2d_cell and km2d_div
//
// s_axis carries one item per transfer. tdata bits from the lowest up:
// seed_index[2:0], pos_x[14:3], pos_y[26:15], foreground[27], zero fill.
// tuser holds op, tlast holds last_pixel.
// m_axis carries results. tdata: cluster_id[2:0], mean_x_out[14:3],
// mean_y_out[26:15], zero fill; tuser is kind, tlast is last.
// cfg_we_i/cfg_wdata_i write num_clusters; the user must write it only
// while idle, as the block does not enforce it. a seed is written to its
// cell as it is taken. a foreground pixel walks the cell chain, one cell a
// cycle, and its label goes out; a background pixel gets no label. the
// block takes one item at a time. a last pixel, after any label, runs two
// serial divisions per active cluster in the one-bit-a-cycle divider.
// reset zeroes means, sums and counts and sets num_clusters to six.
// a stalled receiver holds the output register and the block waits.
module kmeans_2d_point_cluster_pass_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // seed_index, pos_x, pos_y, foreground
  input  logic        s_axis_tuser,  // op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cluster_id, mean_x_out, mean_y_out
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast
);
  import km2d_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StWalk, StLabel, StDivX, StDivY, StMean, StWait
  } st_e;

  st_e st_q;
  logic [2:0] ncfg_q;
  logic [IdBits-1:0] n_act;
  km2d_tok_t tok [MaxClusters+1];
  km2d_tok_t tok_q [MaxClusters];
  km2d_ctl_t ctl;
  logic [SumBits-1:0] sx [MaxClusters];
  logic [SumBits-1:0] sy [MaxClusters];
  logic [CntBits-1:0] cn [MaxClusters];
  logic [IdBits-1:0] k_q;
  logic [IdBits-1:0] best_q;
  logic lastp_q, walk_q;
  logic [CoordBits-1:0] px_q, py_q, mx_q;
  logic [CoordBits-1:0] ctl_my_q;
  logic div_start, div_done;
  logic [SumBits-1:0] div_num, quo;
  logic [CoordBits-1:0] qsat;
  logic [IdBits:0] step_q;
  logic seed_go;
  logic acc;

  assign n_act = (ncfg_q == 3'd0) ? IdBits'(1) :
                 (ncfg_q > 3'(MaxClusters)) ? IdBits'(MaxClusters) : ncfg_q;
  assign s_axis_tready = (st_q == StIdle);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign seed_go = acc && s_axis_tuser == OpSeed;

  assign tok[0].vld = 1'b1;
  assign tok[0].lastp = lastp_q;
  assign tok[0].px = px_q;
  assign tok[0].py = py_q;
  assign tok[0].bd = '0;
  assign tok[0].best = '0;

  assign qsat = (quo > SumBits'({CoordBits{1'b1}})) ? '1 : quo[CoordBits-1:0];

  always_comb begin
    ctl = '0;
    ctl.seed_we = seed_go;
    ctl.seed_x = s_axis_tdata[14:3];
    ctl.seed_y = s_axis_tdata[26:15];
    ctl.add_en = (st_q == StWalk) && step_q == (IdBits+1)'(MaxClusters);
    ctl.add_id = tok_q[MaxClusters-1].best;
    ctl.add_x = px_q;
    ctl.add_y = py_q;
    ctl.ld = (st_q == StDivY) && div_done;
    ctl.clr = ctl.ld;
    ctl.ld_x = mx_q;
    ctl.ld_y = qsat;
  end

  for (genvar i = 0; i < MaxClusters; i++) begin : g_cell
    km2d_cell u_cell (
      .clk_i, .rst_ni,
      .id_i       (IdBits'(i)),
      .active_i   (IdBits'(i) < n_act),
      .seed_sel_i (s_axis_tdata[2:0] == IdBits'(i)),
      .ld_sel_i   (k_q == IdBits'(i)),
      .ctl_i      (ctl),
      .tok_i      ((i == 0) ? tok[0] : tok_q[(i == 0) ? 0 : i-1]),
      .tok_o      (tok[i+1]),
      .sum_x_o    (sx[i]),
      .sum_y_o    (sy[i]),
      .cnt_o      (cn[i])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxClusters; i++) tok_q[i] <= tok[i+1];
  end

  assign div_num = (st_q == StDivX) ? sx[k_q] : sy[k_q];

  km2d_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({1'b0, cn[k_q]} + (CntBits+1)'(1)),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign div_start = walk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ncfg_q <= 3'd6; k_q <= '0; step_q <= '0;
      walk_q <= 1'b0; m_axis_tvalid <= 1'b0; lastp_q <= 1'b0;
      best_q <= '0; px_q <= '0; py_q <= '0; mx_q <= '0;
      m_axis_tuser <= 1'b0; m_axis_tdata <= '0; m_axis_tlast <= 1'b0;
    end else begin
      walk_q <= 1'b0;
      if (cfg_we_i) ncfg_q <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (st_q)
        StIdle: begin
          if (acc && s_axis_tuser == OpPixel) begin
            px_q <= s_axis_tdata[14:3];
            py_q <= s_axis_tdata[26:15];
            lastp_q <= s_axis_tlast;
            k_q <= '0;
            if (s_axis_tdata[27]) begin
              st_q <= StWalk; step_q <= '0;
            end else if (s_axis_tlast) begin
              st_q <= StDivX; walk_q <= 1'b1;
            end
          end
        end
        StWalk: begin
          step_q <= step_q + 1'b1;
          if (step_q == (IdBits+1)'(MaxClusters)) begin
            best_q <= tok_q[MaxClusters-1].best;
            st_q <= StLabel;
          end
        end
        StLabel: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= KindLabel;
            m_axis_tdata <= {29'd0, best_q};
            m_axis_tlast <= !lastp_q;
            if (lastp_q) begin
              st_q <= StDivX; walk_q <= 1'b1;
            end else st_q <= StIdle;
          end
        end
        StDivX: begin
          if (div_done) begin
            mx_q <= qsat; st_q <= StDivY; walk_q <= 1'b1;
          end
        end
        StDivY: begin
          if (div_done) st_q <= StMean;
        end
        StMean: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= KindMean;
            m_axis_tdata <= {5'd0, ctl_my_q, mx_q, k_q};
            m_axis_tlast <= (k_q + 1'b1 == n_act);
            if (k_q + 1'b1 == n_act) st_q <= StWait;
            else begin
              k_q <= k_q + 1'b1; st_q <= StDivX; walk_q <= 1'b1;
            end
          end
        end
        StWait: begin
          if (!m_axis_tvalid || m_axis_tready) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StDivY && div_done) ctl_my_q <= qsat;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> st_q == StIdle) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] < 3'(MaxClusters))
    else $error("cluster id out of range");
endmodule

/* rtl/km2d_cell.sv */
// one cluster cell: mean, sums and count, plus one step of the nearest search
// depends on km2d_pkg
module km2d_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [km2d_pkg::IdBits-1:0]  id_i,
  input  logic                         active_i,
  input  logic                         seed_sel_i,
  input  logic                         ld_sel_i,
  input  km2d_pkg::km2d_ctl_t          ctl_i,
  input  km2d_pkg::km2d_tok_t          tok_i,
  output km2d_pkg::km2d_tok_t          tok_o,
  output logic [km2d_pkg::SumBits-1:0] sum_x_o,
  output logic [km2d_pkg::SumBits-1:0] sum_y_o,
  output logic [km2d_pkg::CntBits-1:0] cnt_o
);
  import km2d_pkg::*;
  logic [CoordBits-1:0] cx_q, cy_q;
  logic [SumBits-1:0] sx_q, sy_q;
  logic [CntBits-1:0] cn_q;
  logic [CoordBits-1:0] dx, dy;
  logic [DistBits-1:0] d;
  logic [SumBits:0] sxn, syn;
  logic [CntBits:0] cnn;
  logic hit;

  always_comb begin
    dx = (tok_i.px > cx_q) ? tok_i.px - cx_q : cx_q - tok_i.px;
    dy = (tok_i.py > cy_q) ? tok_i.py - cy_q : cy_q - tok_i.py;
    d  = DistBits'(dx * dx) + DistBits'(dy * dy);
    tok_o = tok_i;
    if (active_i && (id_i == '0 || d < tok_i.bd)) begin
      tok_o.bd = d;
      tok_o.best = id_i;
    end
    hit = ctl_i.add_en && ctl_i.add_id == id_i;
    sxn = {1'b0, sx_q} + (SumBits+1)'(ctl_i.add_x);
    syn = {1'b0, sy_q} + (SumBits+1)'(ctl_i.add_y);
    cnn = {1'b0, cn_q} + (CntBits+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; sx_q <= '0; sy_q <= '0; cn_q <= '0;
    end else begin
      if (ctl_i.seed_we && seed_sel_i) begin
        cx_q <= ctl_i.seed_x; cy_q <= ctl_i.seed_y;
      end else if (ctl_i.ld && ld_sel_i) begin
        cx_q <= ctl_i.ld_x; cy_q <= ctl_i.ld_y;
      end
      if (ctl_i.clr && (ld_sel_i || !active_i)) begin
        sx_q <= '0; sy_q <= '0; cn_q <= '0;
      end else if (hit) begin
        sx_q <= sxn[SumBits] ? '1 : sxn[SumBits-1:0];
        sy_q <= syn[SumBits] ? '1 : syn[SumBits-1:0];
        cn_q <= cnn[CntBits] ? '1 : cnn[CntBits-1:0];
      end
    end
  end

  assign sum_x_o = sx_q;
  assign sum_y_o = sy_q;
  assign cnt_o   = cn_q;
endmodule

/* rtl/km2d_div.sv */
// serial restoring divider: 36-bit dividend by 26-bit divisor, one bit a cycle
// depends on km2d_pkg
module km2d_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [km2d_pkg::SumBits-1:0] num_i,
  input  logic [km2d_pkg::CntBits:0]   den_i,
  output logic                         done_o,
  output logic [km2d_pkg::SumBits-1:0] quo_o
);
  import km2d_pkg::*;
  localparam int unsigned CntW = $clog2(SumBits + 1);
  logic [SumBits-1:0] q_q;
  logic [CntBits+1:0] r_q;
  logic [CntBits:0] den_q;
  logic [CntW-1:0] n_q;
  logic busy_q;
  logic [CntBits+1:0] sh;

  assign sh = {r_q[CntBits:0], q_q[SumBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; n_q <= '0; done_o <= 1'b0;
      q_q <= '0; r_q <= '0; den_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; n_q <= CntW'(SumBits);
        q_q <= num_i; r_q <= '0; den_q <= den_i;
      end else if (busy_q) begin
        if (sh >= {1'b0, den_q}) begin
          r_q <= sh - {1'b0, den_q};
          q_q <= {q_q[SumBits-2:0], 1'b1};
        end else begin
          r_q <= sh;
          q_q <= {q_q[SumBits-2:0], 1'b0};
        end
        n_q <= n_q - CntW'(1);
        if (n_q == CntW'(1)) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end
  assign quo_o = q_q;
endmodule
